// ===== hw/rtl/gftj_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftj_pkg
// Shared constants, types and codes of the greedy full-text justifier.
// ----------------------------------------------------------------------------
package gftj_pkg;

  // Line geometry.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_WORDS  = 32;
  localparam int CFG_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int USED_W     = 8;

  // Counts that can reach MAX_WIDTH itself, word counts that can reach MAX_WORDS.
  localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
  localparam int WCNT_W     = $clog2(MAX_WORDS + 1);
  localparam int WORD_AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  // Text ring: buffered line plus the word being received.
  localparam int RING_DEPTH = 2 * MAX_WIDTH;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // Divider step counter.
  localparam int DIV_CNT_W  = $clog2(CNT_W + 1);

  localparam logic [BYTE_W-1:0] SPACE_CHAR       = 8'd32;
  localparam logic [CFG_W-1:0]  LINE_WIDTH_RESET = 7'd16;

  // Item classes found by the front end.
  typedef enum logic [1:0] {
    CLS_CHAR,
    CLS_WORD_END,
    CLS_FLUSH
  } item_cls_t;

  typedef struct packed {
    item_cls_t         cls;
    logic [BYTE_W-1:0] text_byte;
  } item_t;

  // Queue port between front and back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_word_t;

  // Back end sequencer.
  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_ISSUE,
    B_LOAD,
    B_COMMIT
  } back_state_t;

  // Walk through the buffered line during output.
  typedef enum logic [1:0] {
    W_NEXT,
    W_CHAR,
    W_GAP,
    W_PAD
  } walk_mode_t;

  typedef struct packed {
    logic               start;
    logic [CNT_W-1:0]   dividend;
    logic [WORD_AW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [CNT_W-1:0]   quotient;
    logic [WORD_AW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hw/rtl/gftj_char_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftj_char_if
// Input channel: one text character or end-of-text mark per word.
// ----------------------------------------------------------------------------
interface gftj_char_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] text_byte;
  logic       word_last;

  modport source (output valid, output action, output text_byte, output word_last,
                  input ready);
  modport sink (input valid, input action, input text_byte, input word_last,
                output ready);
endinterface

// ===== hw/rtl/gftj_line_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftj_line_if
// Output channel: one character of a justified line per word.
// ----------------------------------------------------------------------------
interface gftj_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       line_last;
  logic       text_last;

  modport source (output valid, output out_byte, output line_last, output text_last,
                  input ready);
  modport sink (input valid, input out_byte, input line_last, input text_last,
                output ready);
endinterface

// ===== hw/rtl/gftj_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftj_cfg_if
// Configuration write channel for the line width register.
// ----------------------------------------------------------------------------
interface gftj_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] line_width;

  modport source (output valid, output line_width, input ready);
  modport sink (input valid, input line_width, output ready);
endinterface

// ===== hw/rtl/gftj_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftj_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gftj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gftj_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftj_div
// Restoring divider, one quotient bit per cycle, for the gap widths.
// ----------------------------------------------------------------------------
module gftj_div (
  input  logic               clk,
  input  logic               rst,
  input  gftj_pkg::div_req_t req,
  output gftj_pkg::div_rsp_t rsp
);

  logic                                busy;
  logic [gftj_pkg::DIV_CNT_W-1:0]      cnt;
  logic [gftj_pkg::CNT_W-1:0]          quo;
  logic [gftj_pkg::WORD_AW-1:0]        rem;
  logic [gftj_pkg::WORD_AW-1:0]        dsr;
  logic                                done;
  logic [gftj_pkg::WORD_AW:0]          trial;
  logic                                take;
  logic [gftj_pkg::WORD_AW:0]          diff;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem, quo[gftj_pkg::CNT_W-1]};
    diff  = trial - {1'b0, dsr};
    take  = (trial >= {1'b0, dsr});
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == gftj_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= gftj_pkg::DIV_CNT_W'(gftj_pkg::CNT_W);
      end else if (busy) begin
        cnt <= cnt - gftj_pkg::DIV_CNT_W'(1);
        if (cnt == gftj_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[gftj_pkg::CNT_W-2:0], take};
      rem <= take ? diff[gftj_pkg::WORD_AW-1:0] : trial[gftj_pkg::WORD_AW-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== hw/rtl/gftj_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftj_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module gftj_front (
  input  logic                  clk,
  input  logic                  rst,
  gftj_char_if.sink             chars,
  output gftj_pkg::queue_word_t q_out,
  input  logic                  q_ready
);

  gftj_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;
  logic            pop;
  gftj_pkg::item_t item_in;

  // Classify the incoming word.
  always_comb begin
    item_in.text_byte = chars.text_byte;
    if (chars.action) begin
      item_in.cls = gftj_pkg::CLS_FLUSH;
    end else if (chars.word_last) begin
      item_in.cls = gftj_pkg::CLS_WORD_END;
    end else begin
      item_in.cls = gftj_pkg::CLS_CHAR;
    end
  end

  assign chars.ready = (fill != 2'd2);
  assign push        = chars.valid && chars.ready;
  assign pop         = q_out.valid && q_ready;

  // Two-entry queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  assign q_out.valid = (fill != 2'd0);
  assign q_out.item  = slots[rd_ptr];

endmodule

// ===== hw/rtl/gftj_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftj_back
// Stores words, decides line breaks and streams out justified lines.
// ----------------------------------------------------------------------------
module gftj_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [gftj_pkg::CNT_W-1:0] width,
  input  gftj_pkg::queue_word_t      q_in,
  output logic                       q_ready,
  gftj_line_if.source                lines
);

  gftj_pkg::back_state_t state, state_next;
  gftj_pkg::walk_mode_t  mode, mode_next;

  // Line and word bookkeeping.
  logic [gftj_pkg::RING_AW-1:0] head;
  logic [gftj_pkg::CNT_W-1:0]   ltl;
  logic [gftj_pkg::WCNT_W-1:0]  count;
  logic [gftj_pkg::USED_W-1:0]  used;
  logic [gftj_pkg::CNT_W-1:0]   wl;
  logic [gftj_pkg::CNT_W-1:0]   wl_inc;
  logic                         emit_last;

  // Walker registers.
  logic [gftj_pkg::CNT_W-1:0]   gap;
  logic [gftj_pkg::WORD_AW-1:0] extra;
  logic [gftj_pkg::CNT_W-1:0]   tpos, tpos_next;
  logic [gftj_pkg::WCNT_W-1:0]  nwi, nwi_next;
  logic [gftj_pkg::CNT_W-1:0]   rem, rem_next;
  logic [gftj_pkg::CNT_W-1:0]   gaprem, gaprem_next;
  logic [gftj_pkg::CNT_W-1:0]   col;

  // Output register.
  logic                         out_valid;
  logic [gftj_pkg::BYTE_W-1:0]  out_byte;
  logic                         line_last;
  logic                         text_last;

  // Memories.
  logic                         text_we;
  logic [gftj_pkg::RING_AW-1:0] text_waddr;
  logic [gftj_pkg::RING_AW-1:0] text_raddr;
  logic [gftj_pkg::BYTE_W-1:0]  text_rdata;
  logic                         len_we;
  logic [gftj_pkg::CNT_W-1:0]   len_rdata;

  gftj_pkg::div_req_t div_req;
  gftj_pkg::div_rsp_t div_rsp;

  // Decisions and step values.
  logic                         take_item;
  logic                         is_flush;
  logic                         is_end;
  logic                         need_break;
  logic                         multi_word;
  logic [gftj_pkg::CNT_W-1:0]   spare;
  logic                         load;
  logic                         col_last;
  logic [gftj_pkg::BYTE_W-1:0]  byte_v;
  logic                         word_done;
  logic [gftj_pkg::WCNT_W-1:0]  fin_idx;
  logic [gftj_pkg::CNT_W-1:0]   gap_len;
  logic [gftj_pkg::CNT_W:0]     ltl_sum;

  gftj_ram #(.WIDTH(gftj_pkg::BYTE_W), .DEPTH(gftj_pkg::RING_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_waddr),
    .wdata (q_in.item.text_byte),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  gftj_ram #(.WIDTH(gftj_pkg::CNT_W), .DEPTH(gftj_pkg::MAX_WORDS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (count[gftj_pkg::WORD_AW-1:0]),
    .wdata (wl),
    .raddr (nwi[gftj_pkg::WORD_AW-1:0]),
    .rdata (len_rdata)
  );

  gftj_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Word and line arithmetic on the item at the queue head.
  always_comb begin
    is_flush   = (q_in.item.cls == gftj_pkg::CLS_FLUSH);
    is_end     = (q_in.item.cls == gftj_pkg::CLS_WORD_END);
    wl_inc     = wl + gftj_pkg::CNT_W'(wl < width);
    need_break = (count != '0) &&
                 ((({1'b0, used} + (gftj_pkg::USED_W + 1)'(wl_inc)) >
                   (gftj_pkg::USED_W + 1)'(width)) ||
                  (count >= gftj_pkg::WCNT_W'(gftj_pkg::MAX_WORDS)));
    multi_word = (count > gftj_pkg::WCNT_W'(1));
    spare      = (ltl < width) ? (width - ltl) : '0;
    take_item  = (state == gftj_pkg::B_IDLE) && q_in.valid;
    text_we    = take_item && !is_flush && (wl < width);
    text_waddr = head + gftj_pkg::RING_AW'(ltl) + gftj_pkg::RING_AW'(wl);
    text_raddr = head + gftj_pkg::RING_AW'(tpos);
    len_we     = (state == gftj_pkg::B_COMMIT) &&
                 (count < gftj_pkg::WCNT_W'(gftj_pkg::MAX_WORDS));
    load       = (state == gftj_pkg::B_LOAD) && (!out_valid || lines.ready);
    col_last   = (col == width - gftj_pkg::CNT_W'(1));
    ltl_sum    = {1'b0, ltl} + {1'b0, wl};
  end

  // One step of the walk: the byte for the current column and the next position.
  always_comb begin
    mode_next   = mode;
    rem_next    = rem;
    gaprem_next = gaprem;
    nwi_next    = nwi;
    tpos_next   = tpos;
    byte_v      = gftj_pkg::SPACE_CHAR;
    word_done   = 1'b0;
    fin_idx     = nwi;
    case (mode)
      gftj_pkg::W_NEXT: begin
        if (nwi < count) begin
          byte_v    = text_rdata;
          tpos_next = tpos + gftj_pkg::CNT_W'(1);
          nwi_next  = nwi + gftj_pkg::WCNT_W'(1);
          if (len_rdata > gftj_pkg::CNT_W'(1)) begin
            mode_next = gftj_pkg::W_CHAR;
            rem_next  = len_rdata - gftj_pkg::CNT_W'(1);
          end else begin
            word_done = 1'b1;
          end
        end else begin
          mode_next = gftj_pkg::W_PAD;
        end
      end
      gftj_pkg::W_CHAR: begin
        byte_v    = text_rdata;
        tpos_next = tpos + gftj_pkg::CNT_W'(1);
        rem_next  = rem - gftj_pkg::CNT_W'(1);
        fin_idx   = nwi - gftj_pkg::WCNT_W'(1);
        word_done = (rem == gftj_pkg::CNT_W'(1));
      end
      gftj_pkg::W_GAP: begin
        gaprem_next = gaprem - gftj_pkg::CNT_W'(1);
        if (gaprem == gftj_pkg::CNT_W'(1)) begin
          mode_next = gftj_pkg::W_NEXT;
        end
      end
      default: begin
        mode_next = gftj_pkg::W_PAD;
      end
    endcase
    // The leftmost gaps take one extra space each.
    gap_len = gap + gftj_pkg::CNT_W'(fin_idx < gftj_pkg::WCNT_W'(extra));
    if (word_done) begin
      if ((fin_idx + gftj_pkg::WCNT_W'(1)) < count) begin
        if (gap_len != '0) begin
          mode_next   = gftj_pkg::W_GAP;
          gaprem_next = gap_len;
        end else begin
          mode_next = gftj_pkg::W_NEXT;
        end
      end else begin
        mode_next = gftj_pkg::W_PAD;
      end
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next       = state;
    q_ready          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = spare;
    div_req.divisor  = gftj_pkg::WORD_AW'(count - gftj_pkg::WCNT_W'(1));
    case (state)
      gftj_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_in.valid) begin
          if (is_flush) begin
            state_next = gftj_pkg::B_ISSUE;
          end else if (is_end) begin
            if (need_break && multi_word) begin
              div_req.start = 1'b1;
              state_next    = gftj_pkg::B_DIV;
            end else if (need_break) begin
              state_next = gftj_pkg::B_ISSUE;
            end else begin
              state_next = gftj_pkg::B_COMMIT;
            end
          end
        end
      end
      gftj_pkg::B_DIV: begin
        if (div_rsp.done) begin
          state_next = gftj_pkg::B_ISSUE;
        end
      end
      gftj_pkg::B_ISSUE: begin
        state_next = gftj_pkg::B_LOAD;
      end
      gftj_pkg::B_LOAD: begin
        if (load) begin
          if (!col_last) begin
            state_next = gftj_pkg::B_ISSUE;
          end else if (emit_last) begin
            state_next = gftj_pkg::B_IDLE;
          end else begin
            state_next = gftj_pkg::B_COMMIT;
          end
        end
      end
      gftj_pkg::B_COMMIT: begin
        state_next = gftj_pkg::B_IDLE;
      end
      default: begin
        state_next = gftj_pkg::B_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gftj_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Line bookkeeping: word receive, line clear after output, word commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      ltl   <= '0;
      count <= '0;
      used  <= '0;
      wl    <= '0;
    end else begin
      if (take_item && !is_flush) begin
        wl <= wl_inc;
      end
      if (load && col_last) begin
        head  <= head + gftj_pkg::RING_AW'(ltl);
        ltl   <= '0;
        count <= '0;
        used  <= '0;
        if (emit_last) begin
          wl <= '0;
        end
      end
      if (state == gftj_pkg::B_COMMIT) begin
        if (count < gftj_pkg::WCNT_W'(gftj_pkg::MAX_WORDS)) begin
          count <= count + gftj_pkg::WCNT_W'(1);
        end
        ltl  <= (ltl_sum > (gftj_pkg::CNT_W + 1)'(gftj_pkg::MAX_WIDTH)) ?
                gftj_pkg::CNT_W'(gftj_pkg::MAX_WIDTH) : ltl_sum[gftj_pkg::CNT_W-1:0];
        used <= used + gftj_pkg::USED_W'(wl) + gftj_pkg::USED_W'(1);
        wl   <= '0;
      end
    end
  end

  // Walker: set up at the start of a line, advanced on each output byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= gftj_pkg::W_PAD;
      col  <= '0;
    end else if (take_item && (is_flush || (is_end && need_break))) begin
      mode      <= gftj_pkg::W_NEXT;
      col       <= '0;
      tpos      <= '0;
      nwi       <= '0;
      emit_last <= is_flush;
      gap       <= gftj_pkg::CNT_W'(1);
      extra     <= '0;
    end else begin
      if (div_rsp.done && (state == gftj_pkg::B_DIV)) begin
        gap   <= div_rsp.quotient;
        extra <= div_rsp.remainder;
      end
      if (load) begin
        mode   <= mode_next;
        rem    <= rem_next;
        gaprem <= gaprem_next;
        nwi    <= nwi_next;
        tpos   <= tpos_next;
        col    <= col + gftj_pkg::CNT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (lines.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_v;
      line_last <= col_last;
      text_last <= col_last && emit_last;
    end
  end

  assign lines.valid     = out_valid;
  assign lines.out_byte  = out_byte;
  assign lines.line_last = line_last;
  assign lines.text_last = text_last;

endmodule

// ===== hw/rtl/greedy_full_text_justifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_full_text_justifier
// Greedy line filler with full justification, one output byte per word.
// ----------------------------------------------------------------------------
// Characters enter on chars and wait in a two-entry queue; the back end takes
// a plain character in its idle state. A word end that breaks a line starts a
// gap divide (lines of two or more words), then streams line_width bytes, each
// one read of the single text memory port (ISSUE state) followed by a load of
// the output register (LOAD state); the COMMIT state then commits the word.
// End of text streams line_width bytes the same way. The line width register
// must be written on cfg only while the block is idle; the block itself does
// not enforce this. 0 acts as 1 and values above 64 act as 64.
module greedy_full_text_justifier (
  input logic       clk,
  input logic       rst,
  gftj_char_if.sink chars,
  gftj_line_if.source lines,
  gftj_cfg_if.sink  cfg
);

  logic [gftj_pkg::CFG_W-1:0] line_width;
  logic [gftj_pkg::CNT_W-1:0] width;
  gftj_pkg::queue_word_t      q_word;
  logic                       q_ready;

  // Line width register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= gftj_pkg::LINE_WIDTH_RESET;
    end else if (cfg.valid) begin
      line_width <= cfg.line_width;
    end
  end

  // Clamp the width to the supported range.
  always_comb begin
    if (line_width == '0) begin
      width = gftj_pkg::CNT_W'(1);
    end else if (line_width > gftj_pkg::CFG_W'(gftj_pkg::MAX_WIDTH)) begin
      width = gftj_pkg::CNT_W'(gftj_pkg::MAX_WIDTH);
    end else begin
      width = gftj_pkg::CNT_W'(line_width);
    end
  end

  gftj_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .q_out   (q_word),
    .q_ready (q_ready)
  );

  gftj_back u_back (
    .clk     (clk),
    .rst     (rst),
    .width   (width),
    .q_in    (q_word),
    .q_ready (q_ready),
    .lines   (lines)
  );

endmodule

// ===== tb/greedy_full_text_justifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_full_text_justifier_tb
// Self-checking bench for the greedy full-text justifier.
// ----------------------------------------------------------------------------
// Words of random characters are sent on the character channel under several
// idle and stall patterns. A scoreboard tracks the line store and predicts
// every justified or end-of-text byte, and compares each accepted output word
// with the oldest prediction. The line width is changed between phases.
// ----------------------------------------------------------------------------

class justify_scoreboard;
  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_last;
    logic       text_last;
  } line_char_t;

  line_char_t pending_chars[$];
  int         errors;
  int         checked;
  int         width_reg;
  byte        line_text[64];
  int         word_lens[32];
  int         word_cnt;
  int         text_len;
  int         used_w;
  byte        word_buf[64];
  int         word_len;

  function void clear_all();
    width_reg = 16;
    word_cnt  = 0;
    text_len  = 0;
    used_w    = 0;
    word_len  = 0;
  endfunction

  function int eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > 64) return 64;
    return width_reg;
  endfunction

  // Build one output line from the buffered words.
  function void push_line(bit last_line);
    byte        buf_c[64];
    int         w;
    int         spare;
    int         gap;
    int         extra;
    int         pos;
    int         tpos;
    line_char_t c;
    w     = eff_width();
    spare = (text_len < w) ? w - text_len : 0;
    gap   = 1;
    extra = 0;
    pos   = 0;
    tpos  = 0;
    for (int j = 0; j < 64; j++) buf_c[j] = 8'd32;
    if (!last_line && word_cnt > 1) begin
      gap   = spare / (word_cnt - 1);
      extra = spare % (word_cnt - 1);
    end
    for (int i = 0; i < word_cnt; i++) begin
      for (int k = 0; k < word_lens[i]; k++) begin
        if (pos < w && tpos < 64) buf_c[pos] = line_text[tpos];
        pos++;
        tpos++;
      end
      if (i + 1 < word_cnt) pos += gap + ((!last_line && i < extra) ? 1 : 0);
    end
    for (int j = 0; j < w; j++) begin
      c.out_byte  = buf_c[j];
      c.line_last = (j + 1 == w);
      c.text_last = last_line && (j + 1 == w);
      pending_chars.insert(pending_chars.size(), c);
    end
    word_cnt = 0;
    text_len = 0;
    used_w   = 0;
  endfunction

  // Note one accepted input word.
  function void note_input(bit action, byte text_byte, bit word_last);
    int w;
    w = eff_width();
    if (action) begin
      push_line(1'b1);
      word_len = 0;
      return;
    end
    if (word_len < w) begin
      word_buf[word_len] = text_byte;
      word_len++;
    end
    if (!word_last) return;
    if (word_cnt > 0 && (used_w + word_len > w || word_cnt >= 32)) push_line(1'b0);
    for (int k = 0; k < word_len; k++) begin
      if (text_len < 64) begin
        line_text[text_len] = word_buf[k];
        text_len++;
      end
    end
    if (word_cnt < 32) begin
      word_lens[word_cnt] = word_len;
      word_cnt++;
    end
    used_w   = (used_w + word_len + 1) & 8'hFF;
    word_len = 0;
  endfunction

  // Compare one accepted output word with the oldest prediction.
  function void check_output(logic [7:0] ob, logic ll, logic tl);
    line_char_t e;
    checked++;
    if (pending_chars.size() == 0) begin
      $error("unexpected output word: out_byte %0d", ob);
      errors++;
      return;
    end
    e = pending_chars.pop_front();
    if (ob !== e.out_byte) begin
      $error("out_byte: expected %0d, actual %0d", e.out_byte, ob);
      errors++;
    end
    if (ll !== e.line_last) begin
      $error("line_last: expected %0d, actual %0d", e.line_last, ll);
      errors++;
    end
    if (tl !== e.text_last) begin
      $error("text_last: expected %0d, actual %0d", e.text_last, tl);
      errors++;
    end
  endfunction
endclass

module greedy_full_text_justifier_tb;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   sent_items;

  gftj_char_if chars ();
  gftj_line_if lines ();
  gftj_cfg_if  cfg ();

  justify_scoreboard sb;

  greedy_full_text_justifier DUT (
    .clk  (clk),
    .rst  (rst),
    .chars(chars.sink),
    .lines(lines.source),
    .cfg  (cfg.sink)
  );

  always #2 clk = ~clk;

  // Generous ceiling on the whole run.
  initial begin
    #4000000;
    $display("greedy_full_text_justifier regression: fail");
    $finish;
  end

  // Output side: random stall, check at each accepted word.
  always @(negedge clk) begin
    if (!rst) lines.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && lines.valid && lines.ready)
      sb.check_output(lines.out_byte, lines.line_last, lines.text_last);
  end

  // Send one input word, holding valid until it is taken. Valid stays high
  // afterwards so that back-to-back words need no gap; idle cycles drop it.
  task automatic send_char(bit action, byte tb_byte, bit last_flag);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      chars.valid <= 1'b0;
      @(negedge clk);
    end
    chars.valid     <= 1'b1;
    chars.action    <= action;
    chars.text_byte <= tb_byte;
    chars.word_last <= last_flag;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    sb.note_input(action, tb_byte, last_flag);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_word(int len);
    for (int i = 0; i < len; i++)
      send_char(1'b0, byte'($urandom_range(255)), i == len - 1);
  endtask

  // Wait for all predictions, then let the block settle.
  task automatic drain();
    chars.valid <= 1'b0;
    while (sb.pending_chars.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_width(logic [6:0] value);
    cfg.valid      <= 1'b1;
    cfg.line_width <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.width_reg = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // One random text: mostly well-formed words, then end of text.
  task automatic random_text(int n_words);
    int w;
    w = sb.eff_width();
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(9) == 0) send_word($urandom_range(w + 3, 1));
      else send_word($urandom_range((w < 6) ? w : 6, 1));
    end
    if ($urandom_range(3) == 0) send_char(1'b0, byte'($urandom_range(255)), 1'b0);
    send_char(1'b1, byte'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    clk             = 1'b0;
    rst             = 1'b1;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    sent_items      = 0;
    chars.valid     = 1'b0;
    chars.action    = 1'b0;
    chars.text_byte = 8'd0;
    chars.word_last = 1'b0;
    lines.ready     = 1'b0;
    cfg.valid       = 1'b0;
    cfg.line_width  = 7'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extreme bytes, one-word line, overlong word, empty flush.
    send_char(1'b0, 8'h00, 1'b0);
    send_char(1'b0, 8'hFF, 1'b1);
    send_word(4);
    send_word(6);
    send_word(18);
    send_char(1'b1, 8'hFF, 1'b1);
    send_char(1'b1, 8'h00, 1'b0);
    drain();
    // Width zero acts as one; width above the limit is clamped.
    write_width(7'd0);
    send_word(1);
    send_word(2);
    send_char(1'b1, 8'h00, 1'b0);
    drain();
    write_width(7'd127);
    for (int i = 0; i < 33; i++) send_char(1'b0, 8'h41, 1'b1);
    send_char(1'b1, 8'h00, 1'b0);
    drain();
    // Width cut mid-line: buffer wider than the new width, shrink, then break.
    write_width(7'd64);
    send_word(8);
    send_word(8);
    drain();
    write_width(7'd6);
    send_word(3);
    send_char(1'b1, 8'h00, 1'b0);
    drain();

    // Random phases with different idle patterns and widths.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        3: begin send_idle_pct = 24; recv_stall_pct = 24; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_width(ph == 4 ? 7'd1 : 7'($urandom_range(64, 4)));
      random_text(2);
      drain();
    end

    $display("Sent %0d input words over five idle patterns and widths 0 to 127;",
             sent_items);
    $display("checked %0d output words.", sb.checked);
    if (sb.errors == 0 && sb.pending_chars.size() == 0)
      $display("greedy_full_text_justifier regression: pass");
    else
      $display("greedy_full_text_justifier regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/gftj_pkg.sv
hw/rtl/gftj_char_if.sv
hw/rtl/gftj_line_if.sv
hw/rtl/gftj_cfg_if.sv
hw/rtl/gftj_ram.sv
hw/rtl/gftj_div.sv
hw/rtl/gftj_front.sv
hw/rtl/gftj_back.sv
hw/rtl/greedy_full_text_justifier.sv
tb/greedy_full_text_justifier_tb.sv
